### sv/segment_circle_entry_point_macros.svh
// Assertion macros shared by the segment/circle entry point design.
`ifndef SEGMENT_CIRCLE_ENTRY_POINT_MACROS_SVH
`define SEGMENT_CIRCLE_ENTRY_POINT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SCE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked also during reset.
`define SCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/sce_pkg.sv
// Shared constants and types for the segment/circle entry point pipeline.
package sce_pkg;

    localparam int COORD_BITS  = 32;
    localparam int K_FRAC_BITS = 24;

    localparam int CW   = COORD_BITS;          // coordinate width
    localparam int RW   = COORD_BITS - 2;      // radius width
    localparam int DW   = CW + 1;              // coordinate difference width
    localparam int PW   = 2 * DW;              // product of two differences
    localparam int QW   = 2 * CW + 3;          // quadratic coefficient width
    localparam int MW   = QW - 1;              // coefficient magnitude width
    localparam int HW   = MW / 2;              // half of a magnitude
    localparam int DSW  = 2 * QW;              // discriminant width
    localparam int KW   = K_FRAC_BITS + 1;     // quantized k width
    localparam int SW   = QW + KW;             // square root width
    localparam int NW   = SW + 2;              // root numerator width
    localparam int MB   = K_FRAC_BITS + 2;     // quotient bits of the search index
    localparam int OW   = DW + KW + 1;         // offset product width

    localparam int IDXW = 2;
    localparam logic [IDXW-1:0] REG_CENTER_X = 2'd0;
    localparam logic [IDXW-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [IDXW-1:0] REG_RADIUS   = 2'd2;

    // Per-request data that rides along the pipeline.
    typedef struct packed {
        logic                  ok;
        logic signed [CW-1:0]  px;
        logic signed [CW-1:0]  py;
        logic signed [DW-1:0]  dx;
        logic signed [DW-1:0]  dy;
        logic signed [QW-1:0]  a;
        logic signed [QW-1:0]  h;
    } side_t;

endpackage

### sv/sce_front.sv
// Front end: relative coordinates, quadratic coefficients and discriminant.
module sce_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [sce_pkg::CW-1:0]     prev_x,
    input  logic signed [sce_pkg::CW-1:0]     prev_y,
    input  logic signed [sce_pkg::CW-1:0]     next_x,
    input  logic signed [sce_pkg::CW-1:0]     next_y,
    input  logic signed [sce_pkg::CW-1:0]     center_x,
    input  logic signed [sce_pkg::CW-1:0]     center_y,
    input  logic        [sce_pkg::RW-1:0]     radius,
    output logic                              out_valid,
    output sce_pkg::side_t                    out_side,
    output logic signed [sce_pkg::DSW-1:0]    out_disc
);

    localparam int CW  = sce_pkg::CW;
    localparam int RW  = sce_pkg::RW;
    localparam int DW  = sce_pkg::DW;
    localparam int PW  = sce_pkg::PW;
    localparam int QW  = sce_pkg::QW;
    localparam int MW  = sce_pkg::MW;
    localparam int HW  = sce_pkg::HW;
    localparam int DSW = sce_pkg::DSW;

    // Stage 1: offsets from the center and segment direction
    logic                 v1_reg;
    logic signed [DW-1:0] ax1_reg, ay1_reg, dx1_reg, dy1_reg;
    logic signed [CW-1:0] px1_reg, py1_reg;
    logic signed [DW-1:0] ax1_next, ay1_next, dx1_next, dy1_next;
    logic                 same;

    always_comb begin
        same     = (prev_x == next_x) && (prev_y == next_y);
        ax1_next = DW'(prev_x) - DW'(center_x);
        ay1_next = DW'(prev_y) - DW'(center_y);
        // Coincident ends: aim the segment at the center
        dx1_next = same ? DW'(center_x) - DW'(prev_x) : DW'(next_x) - DW'(prev_x);
        dy1_next = same ? DW'(center_y) - DW'(prev_y) : DW'(next_y) - DW'(prev_y);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
        if (en) begin
            ax1_reg <= ax1_next;
            ay1_reg <= ay1_next;
            dx1_reg <= dx1_next;
            dy1_reg <= dy1_next;
            px1_reg <= prev_x;
            py1_reg <= prev_y;
        end
    end

    // Stage 2: squares and dot products
    logic                   v2_reg;
    logic signed [PW-1:0]   dxdx2_reg, dydy2_reg, dxax2_reg, dyay2_reg, axax2_reg, ayay2_reg;
    logic        [2*RW-1:0] rr2_reg;
    logic signed [DW-1:0]   dx2_reg, dy2_reg;
    logic signed [CW-1:0]   px2_reg, py2_reg;
    logic signed [PW-1:0]   dxdx2_next, dydy2_next, dxax2_next, dyay2_next;
    logic signed [PW-1:0]   axax2_next, ayay2_next;
    logic        [2*RW-1:0] rr2_next;

    always_comb begin
        dxdx2_next = dx1_reg * dx1_reg;
        dydy2_next = dy1_reg * dy1_reg;
        dxax2_next = dx1_reg * ax1_reg;
        dyay2_next = dy1_reg * ay1_reg;
        axax2_next = ax1_reg * ax1_reg;
        ayay2_next = ay1_reg * ay1_reg;
        rr2_next   = (2*RW)'(radius) * (2*RW)'(radius);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            dxdx2_reg <= dxdx2_next;
            dydy2_reg <= dydy2_next;
            dxax2_reg <= dxax2_next;
            dyay2_reg <= dyay2_next;
            axax2_reg <= axax2_next;
            ayay2_reg <= ayay2_next;
            rr2_reg   <= rr2_next;
            dx2_reg   <= dx1_reg;
            dy2_reg   <= dy1_reg;
            px2_reg   <= px1_reg;
            py2_reg   <= py1_reg;
        end
    end

    // Stage 3: coefficients a, h, c
    logic                 v3_reg;
    sce_pkg::side_t       side3_reg, side3_next;
    logic signed [QW-1:0] c3_reg, c3_next;

    always_comb begin
        side3_next.px = px2_reg;
        side3_next.py = py2_reg;
        side3_next.dx = dx2_reg;
        side3_next.dy = dy2_reg;
        side3_next.a  = QW'(dxdx2_reg) + QW'(dydy2_reg);
        side3_next.h  = QW'(dxax2_reg) + QW'(dyay2_reg);
        side3_next.ok = (side3_next.a != '0);
        c3_next       = QW'(axax2_reg) + QW'(ayay2_reg) - $signed(QW'(rr2_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            side3_reg <= side3_next;
            c3_reg    <= c3_next;
        end
    end

    // Stage 4: partial products of h*h and a*c on magnitudes
    logic                v4_reg;
    sce_pkg::side_t      side4_reg;
    logic                csgn4_reg;
    logic [2*HW-1:0]     hll4_reg, hlh4_reg, hhh4_reg;
    logic [2*HW-1:0]     all4_reg, alh4_reg, ahl4_reg, ahh4_reg;
    logic [MW-1:0]       habs, aabs, cabs;
    logic signed [QW-1:0] hneg, cneg;

    always_comb begin
        hneg = -side3_reg.h;
        cneg = -c3_reg;
        habs = side3_reg.h[QW-1] ? hneg[MW-1:0] : side3_reg.h[MW-1:0];
        cabs = c3_reg[QW-1] ? cneg[MW-1:0] : c3_reg[MW-1:0];
        aabs = side3_reg.a[MW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
        if (en) begin
            side4_reg <= side3_reg;
            csgn4_reg <= c3_reg[QW-1];
            hll4_reg  <= (2*HW)'(habs[HW-1:0]) * (2*HW)'(habs[HW-1:0]);
            hlh4_reg  <= (2*HW)'(habs[HW-1:0]) * (2*HW)'(habs[MW-1:HW]);
            hhh4_reg  <= (2*HW)'(habs[MW-1:HW]) * (2*HW)'(habs[MW-1:HW]);
            all4_reg  <= (2*HW)'(aabs[HW-1:0]) * (2*HW)'(cabs[HW-1:0]);
            alh4_reg  <= (2*HW)'(aabs[HW-1:0]) * (2*HW)'(cabs[MW-1:HW]);
            ahl4_reg  <= (2*HW)'(aabs[MW-1:HW]) * (2*HW)'(cabs[HW-1:0]);
            ahh4_reg  <= (2*HW)'(aabs[MW-1:HW]) * (2*HW)'(cabs[MW-1:HW]);
        end
    end

    // Stage 5: combine partial products
    logic                v5_reg;
    sce_pkg::side_t      side5_reg;
    logic                csgn5_reg;
    logic [2*MW-1:0]     h2_5_reg, ac5_reg, h2_5_next, ac5_next;
    logic [2*HW:0]       mid_sum;

    always_comb begin
        mid_sum   = (2*HW+1)'(alh4_reg) + (2*HW+1)'(ahl4_reg);
        h2_5_next = {hhh4_reg, hll4_reg} + ((2*MW)'(hlh4_reg) << (HW + 1));
        ac5_next  = {ahh4_reg, all4_reg} + ((2*MW)'(mid_sum) << HW);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
        if (en) begin
            side5_reg <= side4_reg;
            csgn5_reg <= csgn4_reg;
            h2_5_reg  <= h2_5_next;
            ac5_reg   <= ac5_next;
        end
    end

    // Stage 6: discriminant h*h - a*c, drop negative ones
    logic                  v6_reg;
    sce_pkg::side_t        side6_reg, side6_next;
    logic signed [DSW-1:0] disc6_reg, disc6_next;

    always_comb begin
        disc6_next    = csgn5_reg ? $signed(DSW'(h2_5_reg) + DSW'(ac5_reg))
                                  : $signed(DSW'(h2_5_reg) - DSW'(ac5_reg));
        side6_next    = side5_reg;
        side6_next.ok = side5_reg.ok && !disc6_next[DSW-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
        if (en) begin
            side6_reg <= side6_next;
            disc6_reg <= disc6_next;
        end
    end

    assign out_valid = v6_reg;
    assign out_side  = side6_reg;
    assign out_disc  = disc6_reg;

endmodule

### sv/sce_sqrt.sv
// Pipelined integer square root of the scaled discriminant, one bit per stage.
module sce_sqrt (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  sce_pkg::side_t                  in_side,
    input  logic signed [sce_pkg::DSW-1:0]  in_disc,
    output logic                            out_valid,
    output sce_pkg::side_t                  out_side,
    output logic        [sce_pkg::SW-1:0]   out_root,
    output logic                            out_exact
);

    localparam int SW  = sce_pkg::SW;
    localparam int KW  = sce_pkg::KW;

    logic                 v_reg    [0:SW];
    sce_pkg::side_t       side_reg [0:SW];
    logic [2*SW-1:0]      rad_reg  [0:SW];
    logic [SW:0]          rem_reg  [0:SW];
    logic [SW-1:0]        root_reg [0:SW];

    // Load the radicand: discriminant scaled by the square of the k step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
        if (en) begin
            side_reg[0] <= in_side;
            rad_reg[0]  <= in_side.ok ? {in_disc, {(2*KW){1'b0}}} : '0;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    // One root bit per stage: restoring square root
    for (genvar g = 0; g < SW; g++) begin : g_stage
        logic [SW+2:0] rem_sh, trial, diff;
        logic          ge;
        logic [SW:0]   rem_next;
        logic [SW-1:0] root_next;

        always_comb begin
            rem_sh    = {rem_reg[g], rad_reg[g][2*SW-1 -: 2]};
            trial     = (SW+3)'({root_reg[g], 2'b01});
            ge        = (rem_sh >= trial);
            diff      = rem_sh - trial;
            rem_next  = ge ? diff[SW:0] : rem_sh[SW:0];
            root_next = {root_reg[g][SW-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g+1] <= 1'b0;
            end else if (en) begin
                v_reg[g+1] <= v_reg[g];
            end
            if (en) begin
                side_reg[g+1] <= side_reg[g];
                rad_reg[g+1]  <= rad_reg[g] << 2;
                rem_reg[g+1]  <= rem_next;
                root_reg[g+1] <= root_next;
            end
        end
    end

    assign out_valid = v_reg[SW];
    assign out_side  = side_reg[SW];
    assign out_root  = root_reg[SW];
    assign out_exact = (rem_reg[SW] == '0);

endmodule

### sv/sce_root.sv
// Root selection and pipelined division giving floor(root * 2^(K_FRAC_BITS+1)).
module sce_root (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  sce_pkg::side_t                  in_side,
    input  logic        [sce_pkg::SW-1:0]   in_root,
    input  logic                            in_exact,
    output logic                            out_valid,
    output sce_pkg::side_t                  out_side,
    output logic        [sce_pkg::MB-1:0]   out_m
);

    localparam int SW = sce_pkg::SW;
    localparam int NW = sce_pkg::NW;
    localparam int KW = sce_pkg::KW;
    localparam int MB = sce_pkg::MB;

    // Stage 1: floor and ceiling numerators of both roots, scaled bound
    logic                 v1_reg;
    sce_pkg::side_t       side1_reg;
    logic signed [NW-1:0] lf1_reg, lc1_reg, uf1_reg, uc1_reg, pa1_reg;
    logic signed [NW-1:0] hp, s_lo, s_hi;

    always_comb begin
        hp   = NW'(in_side.h) <<< KW;
        s_lo = $signed(NW'(in_root));
        s_hi = $signed(NW'(in_root) + NW'(!in_exact));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
        if (en) begin
            side1_reg <= in_side;
            lf1_reg   <= -hp - s_hi;
            lc1_reg   <= -hp - s_lo;
            uf1_reg   <= -hp + s_lo;
            uc1_reg   <= -hp + s_hi;
            pa1_reg   <= NW'(in_side.a) <<< KW;
        end
    end

    // Stage 2: pick the lower root if it lies in [0,1], else the upper one if it does; drop the request if neither does
    logic            v2_reg;
    sce_pkg::side_t  side2_reg, side2_next;
    logic [NW-1:0]   num2_reg, num2_next;
    logic            lo_ok, up_ok;

    always_comb begin
        lo_ok         = !lf1_reg[NW-1] && (lc1_reg <= pa1_reg);
        up_ok         = !uf1_reg[NW-1] && (uc1_reg <= pa1_reg);
        side2_next    = side1_reg;
        side2_next.ok = side1_reg.ok && (lo_ok || up_ok);
        if (!side2_next.ok) begin
            num2_next = '0;
        end else if (lo_ok) begin
            num2_next = lf1_reg;
        end else begin
            num2_next = uf1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            side2_reg <= side2_next;
            num2_reg  <= num2_next;
        end
    end

    // Division stages: one quotient bit each, MSB first
    logic            dv_reg   [0:MB];
    sce_pkg::side_t  dside_reg[0:MB];
    logic [NW-1:0]   drem_reg [0:MB];
    logic [MB-1:0]   dq_reg   [0:MB];

    assign dv_reg[0]    = v2_reg;
    assign dside_reg[0] = side2_reg;
    assign drem_reg[0]  = num2_reg;
    assign dq_reg[0]    = '0;

    for (genvar j = 0; j < MB; j++) begin : g_div
        logic [NW-1:0] den, rem_next;
        logic          ge;

        always_comb begin
            den      = NW'(dside_reg[j].a) << (MB - 1 - j);
            ge       = (drem_reg[j] >= den);
            rem_next = ge ? drem_reg[j] - den : drem_reg[j];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[j+1] <= 1'b0;
            end else if (en) begin
                dv_reg[j+1] <= dv_reg[j];
            end
            if (en) begin
                dside_reg[j+1] <= dside_reg[j];
                drem_reg[j+1]  <= rem_next;
                dq_reg[j+1]    <= {dq_reg[j][MB-2:0], ge};
            end
        end
    end

    assign out_valid = dv_reg[MB];
    assign out_side  = dside_reg[MB];
    assign out_m     = dq_reg[MB];

endmodule

### sv/sce_point.sv
// Crossing point from the quantized k, with the output register.
module sce_point (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  sce_pkg::side_t                 in_side,
    input  logic        [sce_pkg::MB-1:0]  in_m,
    output logic                           out_valid,
    output logic                           out_crosses,
    output logic signed [sce_pkg::CW-1:0]  out_x,
    output logic signed [sce_pkg::CW-1:0]  out_y
);

    localparam int CW = sce_pkg::CW;
    localparam int KW = sce_pkg::KW;
    localparam int MB = sce_pkg::MB;
    localparam int OW = sce_pkg::OW;
    localparam int KF = sce_pkg::K_FRAC_BITS;

    // Stage 1: round k to K_FRAC_BITS and scale the direction
    logic                 v1_reg, cross1_reg;
    logic signed [OW-1:0] ox1_reg, oy1_reg;
    logic signed [CW-1:0] px1_reg, py1_reg;
    logic [MB:0]          m_inc;
    logic signed [KW:0]   kq;

    always_comb begin
        m_inc = (MB+1)'(in_m) + (MB+1)'(1);
        kq    = $signed({1'b0, m_inc[KW:1]});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
        if (en) begin
            cross1_reg <= in_side.ok;
            ox1_reg    <= in_side.dx * kq;
            oy1_reg    <= in_side.dy * kq;
            px1_reg    <= in_side.px;
            py1_reg    <= in_side.py;
        end
    end

    // Stage 2: round offsets to whole units and add the start point
    logic                 v2_reg, cross2_reg;
    logic signed [CW-1:0] x2_reg, y2_reg, x2_next, y2_next;
    logic signed [OW-1:0] rx, ry;

    always_comb begin
        rx      = (ox1_reg + (OW'(1) <<< (KF - 1))) >>> KF;
        ry      = (oy1_reg + (OW'(1) <<< (KF - 1))) >>> KF;
        x2_next = cross1_reg ? px1_reg + rx[CW-1:0] : '0;
        y2_next = cross1_reg ? py1_reg + ry[CW-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            cross2_reg <= cross1_reg;
            x2_reg     <= x2_next;
            y2_reg     <= y2_next;
        end
    end

    assign out_valid   = v2_reg;
    assign out_crosses = cross2_reg;
    assign out_x       = x2_reg;
    assign out_y       = y2_reg;

endmodule

### sv/segment_circle_entry_point.sv
// Top level of the segment/circle entry point pipeline.
//
// Usage: write the circle center and radius through the cfg channel (index 0
// center easting, 1 center northing, 2 radius) while no request is in flight.
// Each request on the s_ channel carries a segment (prev, next); one result
// comes out on the m_ channel for every request, in order: m_crosses tells
// whether the segment meets the circle, and m_point_x/y give the first
// crossing walking from prev (zero when there is none).
// From acceptance to m_valid the pipeline has six front stages, one square
// root stage per root bit (93 with the load stage), two root select stages,
// 26 divider stages and two output stages. The pipeline takes one request
// per cycle while the receiver does not stall.
// Reset clears all valid bits and sets center and radius to zero; cfg_ready
// is always high. When the receiver stalls with a result pending, the whole
// pipeline holds and s_ready drops until the result is taken.
`include "segment_circle_entry_point_macros.svh"

module segment_circle_entry_point (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic        [sce_pkg::IDXW-1:0]        cfg_index,
    input  logic        [sce_pkg::CW-1:0]          cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [sce_pkg::CW-1:0]          s_prev_x,
    input  logic signed [sce_pkg::CW-1:0]          s_prev_y,
    input  logic signed [sce_pkg::CW-1:0]          s_next_x,
    input  logic signed [sce_pkg::CW-1:0]          s_next_y,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_crosses,
    output logic signed [sce_pkg::CW-1:0]          m_point_x,
    output logic signed [sce_pkg::CW-1:0]          m_point_y
);

    logic signed [sce_pkg::CW-1:0] center_x_reg, center_y_reg;
    logic        [sce_pkg::RW-1:0] radius_reg;
    logic                          adv;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sce_pkg::REG_CENTER_X: center_x_reg <= cfg_data;
                sce_pkg::REG_CENTER_Y: center_y_reg <= cfg_data;
                sce_pkg::REG_RADIUS:   radius_reg   <= cfg_data[sce_pkg::RW-1:0];
                default: ;
            endcase
        end
    end

    // Advance the pipeline unless a result waits on a stalled receiver
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    logic                            f_valid, q_valid, r_valid;
    sce_pkg::side_t                  f_side, q_side, r_side;
    logic signed [sce_pkg::DSW-1:0]  f_disc;
    logic        [sce_pkg::SW-1:0]   q_root;
    logic                            q_exact;
    logic        [sce_pkg::MB-1:0]   r_m;

    sce_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_valid),
        .prev_x    (s_prev_x),
        .prev_y    (s_prev_y),
        .next_x    (s_next_x),
        .next_y    (s_next_y),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .radius    (radius_reg),
        .out_valid (f_valid),
        .out_side  (f_side),
        .out_disc  (f_disc)
    );

    sce_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (f_valid),
        .in_side   (f_side),
        .in_disc   (f_disc),
        .out_valid (q_valid),
        .out_side  (q_side),
        .out_root  (q_root),
        .out_exact (q_exact)
    );

    sce_root u_root (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (q_valid),
        .in_side   (q_side),
        .in_root   (q_root),
        .in_exact  (q_exact),
        .out_valid (r_valid),
        .out_side  (r_side),
        .out_m     (r_m)
    );

    sce_point u_point (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (adv),
        .in_valid    (r_valid),
        .in_side     (r_side),
        .in_m        (r_m),
        .out_valid   (m_valid),
        .out_crosses (m_crosses),
        .out_x       (m_point_x),
        .out_y       (m_point_y)
    );

    // Checks
    `SCE_ASSERT_IMP(a_zero_point, m_valid && !m_crosses, (m_point_x == '0) && (m_point_y == '0), "point not zero without crossing")
    `SCE_ASSERT_IMP(a_stall_blocks, m_valid && !m_ready, !s_ready, "request taken while result stalled")
    `SCE_ASSERT_NEXT(a_reset_empty, !aresetn, !m_valid, "result valid right after reset")

endmodule
